// ===== design/olu_pkg.sv =====
// ----------------------------------------------------------------------------
// olu_pkg
// Shared types and constants of the ordered value list unit.
// ----------------------------------------------------------------------------
`default_nettype none

package olu_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 32;
    localparam int FUNC_W   = 3;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 40;

    localparam logic [FUNC_W-1:0] FN_APPEND     = 3'd0;
    localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 3'd1;
    localparam logic [FUNC_W-1:0] FN_REMOVE_BACK = 3'd2;
    localparam logic [FUNC_W-1:0] FN_REMOVE_VAL = 3'd3;
    localparam logic [FUNC_W-1:0] FN_FIND       = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef enum logic {
        OLU_IDLE,
        OLU_EXEC
    } olu_state_t;

    // per-cell control from the sequencer
    typedef struct packed {
        logic capture;
        logic in_range;
        logic append_wr;
        logic pop_shift;
        logic rmv_shift;
    } olu_cell_ctrl_t;

endpackage

`default_nettype wire

// ===== design/olu_cell.sv =====
// ----------------------------------------------------------------------------
// olu_cell
// One list entry: holds a value, compares it against the operand and takes
// the value of its right neighbor when the list closes a gap.
// ----------------------------------------------------------------------------
`default_nettype none

module olu_cell (
    input  wire logic                          aclk,
    input  wire olu_pkg::olu_cell_ctrl_t       ctrl,
    input  wire logic [olu_pkg::VAL_W-1:0]     in_value,
    input  wire logic [olu_pkg::VAL_W-1:0]     right_value,
    input  wire logic                          seen_in,
    output logic      [olu_pkg::VAL_W-1:0]     entry,
    output logic                               seen_out
);

    logic [olu_pkg::VAL_W-1:0] entry_reg;
    logic                      match_reg;

    // a match here or anywhere to the left
    assign seen_out = seen_in | match_reg;
    assign entry    = entry_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.capture) begin
            match_reg <= ctrl.in_range && (entry_reg == in_value);
        end
        if (ctrl.append_wr) begin
            entry_reg <= in_value;
        end else if (ctrl.pop_shift || (ctrl.rmv_shift && seen_out)) begin
            entry_reg <= right_value;
        end
    end

endmodule

`default_nettype wire

// ===== design/ordered_value_list_unit.sv =====
// ----------------------------------------------------------------------------
// ordered_value_list_unit
// Bounded ordered list of signed 32-bit values built as a row of cells.
// ----------------------------------------------------------------------------
// In the cycle a beat is accepted every cell compares its entry with the
// operand; in the execute state that follows, the match chain across the
// row resolves and the cells load or shift, writing the result beat into the
// output register. A new beat is accepted while the previous result still
// waits on m_tready; the unit then holds in its execute cycle until the output
// register frees. Entries hold no reset value; only entries below the count
// are ever compared or returned.
`default_nettype none

module ordered_value_list_unit (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // [2:0] func, [34:3] operand_value, [39:35] zero
    input  wire logic [olu_pkg::S_DATA_W-1:0]   s_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // [0] found, [32:1] front_value, [37:33] entry_count, [39:38] status
    output logic      [olu_pkg::M_DATA_W-1:0]   m_tdata
);

    localparam int N   = olu_pkg::CAPACITY;
    localparam int CW  = olu_pkg::CNT_W;
    localparam int VW  = olu_pkg::VAL_W;

    olu_pkg::olu_state_t state_reg, state_next;

    logic [olu_pkg::FUNC_W-1:0] func_reg;
    logic [VW-1:0]              op_value_reg;
    logic [CW-1:0]              count_reg, count_next;
    logic                       m_tvalid_reg;
    logic [olu_pkg::M_DATA_W-1:0] m_tdata_reg;

    logic s_fire, commit, is_empty, is_full;
    logic [VW-1:0] cell_in_value;
    logic [VW-1:0] entry_w [N];
    logic          seen_w  [N+1];
    olu_pkg::olu_cell_ctrl_t ctrl_w [N];

    logic          res_found;
    logic [VW-1:0] res_front;
    logic [1:0]    res_status;

    assign s_fire   = s_tvalid && s_tready;
    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == CW'(N));
    assign commit   = (state_reg == olu_pkg::OLU_EXEC) && (!m_tvalid_reg || m_tready);

    assign cell_in_value = s_fire ? s_tdata[olu_pkg::FUNC_W +: VW] : op_value_reg;
    assign seen_w[0]     = 1'b0;

    for (genvar i = 0; i < N; i++) begin : g_cell
        always_comb begin
            ctrl_w[i].capture   = s_fire;
            ctrl_w[i].in_range  = (CW'(i) < count_reg);
            ctrl_w[i].append_wr = commit && (func_reg == olu_pkg::FN_APPEND) && !is_full
                                  && (count_reg == CW'(i));
            ctrl_w[i].pop_shift = commit && (func_reg == olu_pkg::FN_POP_FRONT) && !is_empty;
            ctrl_w[i].rmv_shift = commit && (func_reg == olu_pkg::FN_REMOVE_VAL) && !is_empty;
        end

        olu_cell u_cell (
            .aclk        (aclk),
            .ctrl        (ctrl_w[i]),
            .in_value    (cell_in_value),
            .right_value ((i == N - 1) ? entry_w[i] : entry_w[(i + 1) % N]),
            .seen_in     (seen_w[i]),
            .entry       (entry_w[i]),
            .seen_out    (seen_w[i+1])
        );
    end

    // state machine
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= olu_pkg::OLU_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        case (state_reg)
            olu_pkg::OLU_IDLE: begin
                // no beat is taken while reset is held
                s_tready = aresetn;
                if (s_tvalid) begin
                    state_next = olu_pkg::OLU_EXEC;
                end
            end
            olu_pkg::OLU_EXEC: begin
                if (commit) begin
                    state_next = olu_pkg::OLU_IDLE;
                end
            end
            default: begin
                state_next = olu_pkg::OLU_IDLE;
            end
        endcase
    end

    // result and next count
    always_comb begin
        count_next = count_reg;
        res_found  = 1'b0;
        res_front  = '0;
        res_status = olu_pkg::ST_OK;
        case (func_reg)
            olu_pkg::FN_APPEND: begin
                if (is_full) begin
                    res_status = olu_pkg::ST_FULL;
                end else begin
                    count_next = count_reg + CW'(1);
                end
            end
            olu_pkg::FN_POP_FRONT: begin
                if (is_empty) begin
                    res_status = olu_pkg::ST_EMPTY;
                end else begin
                    res_front  = entry_w[0];
                    count_next = count_reg - CW'(1);
                end
            end
            olu_pkg::FN_REMOVE_BACK: begin
                if (is_empty) begin
                    res_status = olu_pkg::ST_EMPTY;
                end else begin
                    count_next = count_reg - CW'(1);
                end
            end
            olu_pkg::FN_REMOVE_VAL: begin
                if (is_empty) begin
                    res_status = olu_pkg::ST_EMPTY;
                end else if (seen_w[N]) begin
                    res_found  = 1'b1;
                    count_next = count_reg - CW'(1);
                end
            end
            olu_pkg::FN_FIND: begin
                res_found = seen_w[N];
            end
            default: begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            func_reg     <= s_tdata[olu_pkg::FUNC_W-1:0];
            op_value_reg <= s_tdata[olu_pkg::FUNC_W +: VW];
        end
        if (commit) begin
            m_tdata_reg <= {res_status, 5'(count_next), res_front, res_found};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (commit) begin
                count_reg <= count_next;
            end
            if (commit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // assertions
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(N))
        else $error("entry count above capacity");

    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> (state_reg == olu_pkg::OLU_EXEC))
        else $error("accepted beat did not enter execute");

    a_append_grow: assert property (@(posedge aclk) disable iff (!aresetn)
        (commit && func_reg == olu_pkg::FN_APPEND && !is_full)
        |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("append did not grow the list");

    a_count_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !commit |=> (count_reg == $past(count_reg)))
        else $error("count changed outside a commit");

endmodule

`default_nettype wire

// ===== dv/ordered_value_list_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_value_list_unit_test
// Self-checking bench for the ordered value list unit. A directed table hits
// the empty and full corners, the value extremes and the unused function
// codes. Bursts of random commands then push the list to full and back to
// empty. Each result beat is checked against its table row or a shadow copy of the list.
// ----------------------------------------------------------------------------

module ordered_value_list_unit_test;

    // function codes the unit leaves undefined
    localparam logic [olu_pkg::FUNC_W-1:0] FN_RSVD_5 = 3'd5;
    localparam logic [olu_pkg::FUNC_W-1:0] FN_RSVD_6 = 3'd6;
    localparam logic [olu_pkg::FUNC_W-1:0] FN_RSVD_7 = 3'd7;

    localparam int RANDOM_BEATS = 600;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic                      found;
        logic [olu_pkg::VAL_W-1:0] front_value;
        logic [4:0]                entry_count;
        logic [1:0]                status;
    } list_result_t;

    typedef struct packed {
        logic [olu_pkg::FUNC_W-1:0] fn;
        logic [olu_pkg::VAL_W-1:0]  operand;
        int                         repeats;
        bit                         fixed;
        list_result_t               want;
    } list_cmd_row_t;

    logic                         aclk     = 1'b0;
    logic                         aresetn  = 1'b0;
    logic                         s_tvalid = 1'b0;
    logic                         s_tready;
    logic [olu_pkg::S_DATA_W-1:0] s_tdata  = '0;
    logic                         m_tvalid;
    logic                         m_tready = 1'b0;
    logic [olu_pkg::M_DATA_W-1:0] m_tdata;

    // shadow of the list contents
    logic [olu_pkg::VAL_W-1:0] shadow_vals [olu_pkg::CAPACITY];
    int                        shadow_cnt;

    list_result_t pending_results[$];
    int           fails;
    int           beats_sent;
    int           empty_rejects;
    int           full_rejects;
    int           lookup_hits;
    int           stall_left;
    bit           calm;

    list_cmd_row_t dir_tbl [0:24];

    ordered_value_list_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // mostly short idles, now and then a long one
    function automatic int idle_len();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(5, 25);
    endfunction

    function automatic logic [olu_pkg::VAL_W-1:0] pick_operand();
        logic [olu_pkg::VAL_W-1:0] pool [8];
        pool = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000,
                 32'h7FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678};
        // a small pool keeps matches and duplicates frequent
        if ($urandom_range(0, 9) < 6)
            return pool[3'($urandom_range(0, 7))];
        return $urandom;
    endfunction

    function automatic void drop_entry(input int at);
        for (int i = at; i + 1 < shadow_cnt; i++)
            shadow_vals[i] = shadow_vals[i + 1];
        shadow_cnt--;
    endfunction

    function automatic list_result_t predict_list_op(
        input logic [olu_pkg::FUNC_W-1:0] fn,
        input logic [olu_pkg::VAL_W-1:0]  v);
        list_result_t r;
        int           hit;
        r   = '0;
        hit = -1;
        case (fn)
            olu_pkg::FN_APPEND: begin
                if (shadow_cnt >= olu_pkg::CAPACITY) begin
                    r.status = olu_pkg::ST_FULL;
                    full_rejects++;
                end else begin
                    shadow_vals[shadow_cnt] = v;
                    shadow_cnt++;
                end
            end
            olu_pkg::FN_POP_FRONT, olu_pkg::FN_REMOVE_BACK, olu_pkg::FN_REMOVE_VAL: begin
                if (shadow_cnt == 0) begin
                    r.status = olu_pkg::ST_EMPTY;
                    empty_rejects++;
                end else if (fn == olu_pkg::FN_POP_FRONT) begin
                    r.front_value = shadow_vals[0];
                    drop_entry(0);
                end else if (fn == olu_pkg::FN_REMOVE_BACK) begin
                    shadow_cnt--;
                end else begin
                    for (int i = 0; i < shadow_cnt; i++)
                        if (hit < 0 && shadow_vals[i] == v)
                            hit = i;
                    if (hit >= 0) begin
                        r.found = 1'b1;
                        drop_entry(hit);
                    end
                end
            end
            olu_pkg::FN_FIND: begin
                for (int i = 0; i < shadow_cnt; i++)
                    if (shadow_vals[i] == v)
                        r.found = 1'b1;
            end
            default: ;
        endcase
        if (r.found)
            lookup_hits++;
        r.entry_count = shadow_cnt[4:0];
        return r;
    endfunction

    task automatic send_cmd(input logic [olu_pkg::FUNC_W-1:0] fn,
                            input logic [olu_pkg::VAL_W-1:0] v,
                            input bit fixed, input list_result_t want);
        int           gap;
        list_result_t model;
        gap = (calm || $urandom_range(0, 1) == 0) ? 0 : idle_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(olu_pkg::S_DATA_W - olu_pkg::FUNC_W - olu_pkg::VAL_W){1'b0}}, v, fn};
        do @(posedge aclk); while (!s_tready);
        model = predict_list_op(fn, v);
        pending_results.push_back(fixed ? want : model);
        beats_sent++;
    endtask

    // result side back-pressure
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_tready <= 1'b1;
            if (!calm && $urandom_range(0, 3) == 0)
                stall_left <= idle_len();
        end
    end

    always @(posedge aclk) begin
        list_result_t got;
        list_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[0], m_tdata[32:1], m_tdata[37:33], m_tdata[39:38]};
            if (pending_results.size() == 0) begin
                fails++;
                if (fails <= MAX_REPORTS)
                    $display("unexpected result beat: found %0d front %h count %0d status %0d",
                             got.found, got.front_value, got.entry_count, got.status);
            end else begin
                want = pending_results.pop_front();
                if (got.found !== want.found || got.front_value !== want.front_value ||
                    got.entry_count !== want.entry_count || got.status !== want.status) begin
                    fails++;
                    if (fails <= MAX_REPORTS)
                        $display({"mismatch at %0t: found %0d/%0d front %h/%h ",
                                  "count %0d/%0d status %0d/%0d (expected/actual)"},
                                 $realtime, want.found, got.found, want.front_value,
                                 got.front_value, want.entry_count, got.entry_count,
                                 want.status, got.status);
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("ordered_value_list_unit test failed");
        $finish;
    end

    initial begin
        int                         sent;
        int                         burst;
        bit                         filling;
        int                         roll;
        logic [olu_pkg::FUNC_W-1:0] fn;
        shadow_cnt    = 0;
        fails         = 0;
        beats_sent    = 0;
        empty_rejects = 0;
        full_rejects  = 0;
        lookup_hits   = 0;
        stall_left    = 0;
        calm          = 1'b0;

        dir_tbl = '{
            // empty list corners straight out of reset
            '{olu_pkg::FN_POP_FRONT, 32'h0000_0000, 1, 1'b1,
              '{1'b0, 32'h0, 5'd0, olu_pkg::ST_EMPTY}},
            '{olu_pkg::FN_REMOVE_BACK, 32'h0000_0000, 1, 1'b1,
              '{1'b0, 32'h0, 5'd0, olu_pkg::ST_EMPTY}},
            '{olu_pkg::FN_REMOVE_VAL, 32'h8000_0000, 1, 1'b1,
              '{1'b0, 32'h0, 5'd0, olu_pkg::ST_EMPTY}},
            '{olu_pkg::FN_FIND, 32'h7FFF_FFFF, 1, 1'b1,
              '{1'b0, 32'h0, 5'd0, olu_pkg::ST_OK}},
            '{FN_RSVD_5, 32'hFFFF_FFFF, 1, 1'b1,
              '{1'b0, 32'h0, 5'd0, olu_pkg::ST_OK}},
            // remove back on a single entry empties the list
            '{olu_pkg::FN_APPEND, 32'h8000_0000, 1, 1'b1,
              '{1'b0, 32'h0, 5'd1, olu_pkg::ST_OK}},
            '{olu_pkg::FN_REMOVE_BACK, 32'h0000_0000, 1, 1'b1,
              '{1'b0, 32'h0, 5'd0, olu_pkg::ST_OK}},
            '{olu_pkg::FN_APPEND, 32'h7FFF_FFFF, 1, 1'b1,
              '{1'b0, 32'h0, 5'd1, olu_pkg::ST_OK}},
            '{olu_pkg::FN_APPEND, 32'h8000_0000, 1, 1'b1,
              '{1'b0, 32'h0, 5'd2, olu_pkg::ST_OK}},
            '{olu_pkg::FN_APPEND, 32'hFFFF_FFFF, 1, 1'b1,
              '{1'b0, 32'h0, 5'd3, olu_pkg::ST_OK}},
            '{olu_pkg::FN_APPEND, 32'h0000_0000, 1, 1'b1,
              '{1'b0, 32'h0, 5'd4, olu_pkg::ST_OK}},
            '{olu_pkg::FN_APPEND, 32'hFFFF_FFFF, 1, 1'b1,
              '{1'b0, 32'h0, 5'd5, olu_pkg::ST_OK}},
            '{olu_pkg::FN_FIND, 32'h7FFF_FFFF, 1, 1'b1,
              '{1'b1, 32'h0, 5'd5, olu_pkg::ST_OK}},
            // duplicate: only the first copy goes
            '{olu_pkg::FN_REMOVE_VAL, 32'hFFFF_FFFF, 1, 1'b1,
              '{1'b1, 32'h0, 5'd4, olu_pkg::ST_OK}},
            '{olu_pkg::FN_REMOVE_VAL, 32'h0001_2345, 1, 1'b1,
              '{1'b0, 32'h0, 5'd4, olu_pkg::ST_OK}},
            '{olu_pkg::FN_POP_FRONT, 32'h0000_0000, 1, 1'b1,
              '{1'b0, 32'h7FFF_FFFF, 5'd3, olu_pkg::ST_OK}},
            '{FN_RSVD_6, 32'h8000_0000, 1, 1'b0, '0},
            '{FN_RSVD_7, 32'h0000_0000, 1, 1'b0, '0},
            // fill to capacity, then one append too many
            '{olu_pkg::FN_APPEND, 32'h5A5A_0000, 13, 1'b0, '0},
            '{olu_pkg::FN_APPEND, 32'h0000_0001, 1, 1'b1,
              '{1'b0, 32'h0, 5'd16, olu_pkg::ST_FULL}},
            '{olu_pkg::FN_FIND, 32'h5A5A_000C, 1, 1'b0, '0},
            '{olu_pkg::FN_REMOVE_VAL, 32'h5A5A_000C, 1, 1'b0, '0},
            '{olu_pkg::FN_REMOVE_VAL, 32'h8000_0000, 1, 1'b0, '0},
            '{olu_pkg::FN_POP_FRONT, 32'h0000_0000, 1, 1'b0, '0},
            '{olu_pkg::FN_REMOVE_BACK, 32'h0000_0000, 1, 1'b0, '0}
        };

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_tbl[r])
            for (int k = 0; k < dir_tbl[r].repeats; k++)
                send_cmd(dir_tbl[r].fn, dir_tbl[r].operand + k, dir_tbl[r].fixed,
                         dir_tbl[r].want);

        // bursts that lean toward filling or draining the list
        sent = 0;
        while (sent < RANDOM_BEATS) begin
            burst   = $urandom_range(8, 40);
            filling = ($urandom_range(0, 1) == 1);
            calm    = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < burst; k++) begin
                roll = $urandom_range(0, 99);
                if (roll < 3)
                    case ($urandom_range(0, 2))
                        0: fn = FN_RSVD_5;
                        1: fn = FN_RSVD_6;
                        default: fn = FN_RSVD_7;
                    endcase
                else if (roll < (filling ? 63 : 28))
                    fn = olu_pkg::FN_APPEND;
                else
                    case ($urandom_range(0, 3))
                        0: fn = olu_pkg::FN_POP_FRONT;
                        1: fn = olu_pkg::FN_REMOVE_BACK;
                        2: fn = olu_pkg::FN_REMOVE_VAL;
                        default: fn = olu_pkg::FN_FIND;
                    endcase
                send_cmd(fn, pick_operand(), 1'b0, '0);
                sent++;
            end
        end
        s_tvalid <= 1'b0;
        calm     = 1'b0;

        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("%0d command beats sent, %0d lookups matched", beats_sent, lookup_hits);
        $display("%0d empty-list rejects and %0d full-list rejects seen",
                 empty_rejects, full_rejects);
        if (fails == 0)
            $display("ordered_value_list_unit test passed");
        else
            $display("ordered_value_list_unit test failed");
        $finish;
    end

endmodule
